// ===== rtl/sfd_pkg.sv =====
// shared types, constants and field decode for the status frame deframer
package sfd_pkg;

  // frame layout
  localparam int CAPTURE_BYTES = 14;
  localparam int CAP_IDX_W = $clog2(CAPTURE_BYTES);
  localparam int POS_W = 17;
  localparam logic [7:0] START_BYTE = 8'hA5;
  localparam logic [15:0] CMD_STATUS = 16'h0201;
  localparam logic [15:0] CMD_POWER = 16'h0202;
  localparam logic [POS_W-1:0] FRAME_OVERHEAD = 17'd9;
  localparam logic [POS_W-1:0] PAYLOAD_OFFSET = 17'd7;
  localparam logic [POS_W-1:0] CAPTURE_END = PAYLOAD_OFFSET + POS_W'(CAPTURE_BYTES);
  localparam logic [POS_W-1:0] POS_LEN_LO = 17'd1;
  localparam logic [POS_W-1:0] POS_LEN_HI = 17'd2;
  localparam logic [POS_W-1:0] POS_CMD_LO = 17'd5;
  localparam logic [POS_W-1:0] POS_CMD_HI = 17'd6;
  localparam logic [POS_W-1:0] POS_MIN_END = 17'd3;
  localparam logic [15:0] STATUS_MIN_LEN = 16'd13;
  localparam logic [15:0] POWER_LEN = 16'd14;

  // output bits of the power management byte
  localparam logic [7:0] PM_GIMBAL = 8'h01;
  localparam logic [7:0] PM_CHASSIS = 8'h02;
  localparam logic [7:0] PM_SHOOTER = 8'h04;

  // field ids
  localparam logic [3:0] FID_ROBOT_ID = 4'd0;
  localparam logic [3:0] FID_LEVEL = 4'd1;
  localparam logic [3:0] FID_HP = 4'd2;
  localparam logic [3:0] FID_MAX_HP = 4'd3;
  localparam logic [3:0] FID_COOLING = 4'd4;
  localparam logic [3:0] FID_HEAT_LIMIT = 4'd5;
  localparam logic [3:0] FID_POWER_LIMIT = 4'd6;
  localparam logic [3:0] FID_GIMBAL = 4'd7;
  localparam logic [3:0] FID_CHASSIS = 4'd8;
  localparam logic [3:0] FID_SHOOTER = 4'd9;
  localparam logic [3:0] FID_BUFFER = 4'd10;
  localparam logic [3:0] FID_HEAT17 = 4'd11;
  localparam logic [3:0] FID_HEAT42 = 4'd12;

  // fields per frame kind
  localparam logic [3:0] STATUS_LAST_STEP = 4'd9;
  localparam logic [3:0] POWER_LAST_STEP = 4'd2;

  // queue depths (powers of two so pointers wrap naturally)
  localparam int JOB_DEPTH = 2;
  localparam int JOB_PTR_W = $clog2(JOB_DEPTH);
  localparam int JOB_CNT_W = $clog2(JOB_DEPTH + 1);
  localparam int RES_DEPTH = 8;
  localparam int RES_PTR_W = $clog2(RES_DEPTH);
  localparam int RES_CNT_W = $clog2(RES_DEPTH + 1);

  typedef logic [CAPTURE_BYTES-1:0][7:0] cap_bytes_t;

  // one decoded frame waiting to be expanded into fields
  typedef struct packed {
    logic is_power;
    cap_bytes_t cap;
  } job_t;

  // one result item
  typedef struct packed {
    logic [3:0] fid;
    logic [15:0] value;
    logic last;
  } res_t;

  // value of one field taken from the captured payload
  function automatic logic [15:0] field_value(input cap_bytes_t cap, input logic [3:0] fid);
    logic [15:0] v;
    v = '0;
    case (fid)
      FID_ROBOT_ID: v = {8'h00, cap[0]};
      FID_LEVEL: v = {8'h00, cap[1]};
      FID_HP: v = {cap[3], cap[2]};
      FID_MAX_HP: v = {cap[5], cap[4]};
      FID_COOLING: v = {cap[7], cap[6]};
      FID_HEAT_LIMIT: v = {cap[9], cap[8]};
      FID_POWER_LIMIT: v = {cap[11], cap[10]};
      FID_GIMBAL: v = {15'd0, (cap[12] & PM_GIMBAL) != 8'h00};
      FID_CHASSIS: v = {15'd0, (cap[12] & PM_CHASSIS) != 8'h00};
      FID_SHOOTER: v = {15'd0, (cap[12] & PM_SHOOTER) != 8'h00};
      FID_BUFFER: v = {cap[9], cap[8]};
      FID_HEAT17: v = {cap[11], cap[10]};
      FID_HEAT42: v = {cap[13], cap[12]};
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

// ===== rtl/sfd_front.sv =====
// front end: byte parser that hunts, tracks the frame and hands off decoded frames
module sfd_front (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  input  logic [7:0]         data_byte,
  input  logic               buffer_end,
  input  logic               job_full,
  output logic               full,
  output logic               job_push,
  output sfd_pkg::job_t      job_data
);

  typedef enum logic [1:0] {
    PH_HUNT  = 2'b01,
    PH_FRAME = 2'b10
  } phase_t;

  phase_t phase, phase_next;
  logic [sfd_pkg::POS_W-1:0] pos, pos_next;
  logic [sfd_pkg::POS_W-1:0] pos_inc;
  logic [sfd_pkg::POS_W-1:0] frame_end;
  logic [15:0] len;
  logic [15:0] cmd;
  sfd_pkg::cap_bytes_t cap;
  logic accept;
  logic in_frame;
  logic done;
  logic cap_hit;
  logic [sfd_pkg::CAP_IDX_W-1:0] cap_idx;
  logic is_status;
  logic is_power;

  // accept whenever the hand-off queue has room
  assign full = job_full;
  assign accept = push & ~job_full;
  assign in_frame = (phase == PH_FRAME);

  // frame position and end detection
  assign pos_inc = pos + 17'd1;
  assign frame_end = sfd_pkg::FRAME_OVERHEAD + {1'b0, len};
  assign done = in_frame && (pos_inc >= sfd_pkg::POS_MIN_END) && (pos_inc == frame_end);

  // payload capture window
  assign cap_hit = in_frame && (pos >= sfd_pkg::PAYLOAD_OFFSET) && (pos < sfd_pkg::CAPTURE_END);
  assign cap_idx = sfd_pkg::CAP_IDX_W'(pos - sfd_pkg::PAYLOAD_OFFSET);

  // frame classification
  assign is_status = (cmd == sfd_pkg::CMD_STATUS) && (len >= sfd_pkg::STATUS_MIN_LEN);
  assign is_power = (cmd == sfd_pkg::CMD_POWER) && (len == sfd_pkg::POWER_LEN);

  // hand off only frames that produce fields
  assign job_push = accept && done && (is_status || is_power);
  assign job_data.is_power = is_power;
  assign job_data.cap = cap;

  // phase and position update
  always_comb begin
    phase_next = phase;
    pos_next = pos;
    case (phase)
      PH_FRAME: begin
        if (done) begin
          phase_next = PH_HUNT;
          pos_next = '0;
        end else begin
          pos_next = pos_inc;
        end
      end
      default: begin
        if (data_byte == sfd_pkg::START_BYTE) begin
          phase_next = PH_FRAME;
          pos_next = 17'd1;
        end
      end
    endcase
    if (buffer_end) begin
      phase_next = PH_HUNT;
      pos_next = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_HUNT;
      pos <= '0;
    end else if (accept) begin
      phase <= phase_next;
      pos <= pos_next;
    end
  end

  // header fields
  always_ff @(posedge clk) begin
    if (rst) begin
      len <= '0;
      cmd <= '0;
    end else if (accept && in_frame) begin
      case (pos)
        sfd_pkg::POS_LEN_LO: len[7:0] <= data_byte;
        sfd_pkg::POS_LEN_HI: len[15:8] <= data_byte;
        sfd_pkg::POS_CMD_LO: cmd[7:0] <= data_byte;
        sfd_pkg::POS_CMD_HI: cmd[15:8] <= data_byte;
        default: ;
      endcase
    end
  end

  // payload bytes, no reset
  always_ff @(posedge clk) begin
    if (accept && cap_hit) begin
      cap[cap_idx] <= data_byte;
    end
  end

`ifndef ASSERT_OFF
  a_hunt_pos_zero: assert property (@(posedge clk) disable iff (rst)
    (phase == PH_HUNT) |-> (pos == '0))
    else $error("position not cleared while hunting");
  a_push_room: assert property (@(posedge clk) disable iff (rst)
    job_push |-> (!job_full && done))
    else $error("frame handed off without room or before its end");
`endif

endmodule

// ===== rtl/sfd_job_queue.sv =====
// short queue of decoded frames between the parser and the field sequencer
module sfd_job_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  sfd_pkg::job_t push_data,
  input  logic          pop,
  output logic          full,
  output logic          valid,
  output sfd_pkg::job_t head
);

  sfd_pkg::job_t entries [sfd_pkg::JOB_DEPTH];
  logic [sfd_pkg::JOB_PTR_W-1:0] wr_ptr;
  logic [sfd_pkg::JOB_PTR_W-1:0] rd_ptr;
  logic [sfd_pkg::JOB_CNT_W-1:0] count;
  logic do_push;
  logic do_pop;

  assign full = (count == sfd_pkg::JOB_CNT_W'(sfd_pkg::JOB_DEPTH));
  assign valid = (count != '0);
  assign head = entries[rd_ptr];
  assign do_push = push & ~full;
  assign do_pop = pop & valid;

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
    end else begin
      if (do_push) wr_ptr <= wr_ptr + 1'b1;
      if (do_pop) rd_ptr <= rd_ptr + 1'b1;
      if (do_push && !do_pop) count <= count + 1'b1;
      else if (do_pop && !do_push) count <= count - 1'b1;
    end
  end

  // entry storage
  always_ff @(posedge clk) begin
    if (do_push) entries[wr_ptr] <= push_data;
  end

`ifndef ASSERT_OFF
  a_job_count: assert property (@(posedge clk) disable iff (rst)
    count <= sfd_pkg::JOB_CNT_W'(sfd_pkg::JOB_DEPTH))
    else $error("frame queue count out of range");
`endif

endmodule

// ===== rtl/sfd_back.sv =====
// back end: expands one decoded frame into its field items, one per cycle while the result queue has room
module sfd_back (
  input  logic          clk,
  input  logic          rst,
  input  logic          job_valid,
  input  sfd_pkg::job_t job_data,
  input  logic          res_full,
  output logic          job_pop,
  output logic          res_push,
  output sfd_pkg::res_t res_data
);

  logic [3:0] step;
  logic [3:0] fid;
  logic last;

  // field id and last flag from the frame kind and step
  assign fid = job_data.is_power ? (sfd_pkg::FID_BUFFER + step) : step;
  assign last = job_data.is_power ? (step == sfd_pkg::POWER_LAST_STEP)
                                  : (step == sfd_pkg::STATUS_LAST_STEP);

  assign res_push = job_valid & ~res_full;
  assign job_pop = res_push & last;
  assign res_data.fid = fid;
  assign res_data.value = sfd_pkg::field_value(job_data.cap, fid);
  assign res_data.last = last;

  // step through the fields of the head frame
  always_ff @(posedge clk) begin
    if (rst) begin
      step <= '0;
    end else if (res_push) begin
      if (last) step <= '0;
      else step <= step + 4'd1;
    end
  end

`ifndef ASSERT_OFF
  a_step_range: assert property (@(posedge clk) disable iff (rst)
    job_valid |-> (job_data.is_power ? (step <= sfd_pkg::POWER_LAST_STEP)
                                     : (step <= sfd_pkg::STATUS_LAST_STEP)))
    else $error("field step past the end of its frame");
`endif

endmodule

// ===== rtl/sfd_result_queue.sv =====
// result queue holding field items until they are popped
module sfd_result_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  sfd_pkg::res_t push_data,
  input  logic          pop,
  output logic          full,
  output logic          empty,
  output sfd_pkg::res_t head
);

  sfd_pkg::res_t entries [sfd_pkg::RES_DEPTH];
  logic [sfd_pkg::RES_PTR_W-1:0] wr_ptr;
  logic [sfd_pkg::RES_PTR_W-1:0] rd_ptr;
  logic [sfd_pkg::RES_CNT_W-1:0] count;
  logic do_push;
  logic do_pop;

  assign full = (count == sfd_pkg::RES_CNT_W'(sfd_pkg::RES_DEPTH));
  assign empty = (count == '0);
  assign head = entries[rd_ptr];
  assign do_push = push & ~full;
  assign do_pop = pop & ~empty;

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
    end else begin
      if (do_push) wr_ptr <= wr_ptr + 1'b1;
      if (do_pop) rd_ptr <= rd_ptr + 1'b1;
      if (do_push && !do_pop) count <= count + 1'b1;
      else if (do_pop && !do_push) count <= count - 1'b1;
    end
  end

  // entry storage
  always_ff @(posedge clk) begin
    if (do_push) entries[wr_ptr] <= push_data;
  end

`ifndef ASSERT_OFF
  a_res_count: assert property (@(posedge clk) disable iff (rst)
    count <= sfd_pkg::RES_CNT_W'(sfd_pkg::RES_DEPTH))
    else $error("result queue count out of range");
`endif

endmodule

// ===== rtl/status_frame_deframer_unit.sv =====
// top level of the status frame deframer: parser, frame queue, field sequencer, result queue
//
//   channel   direction  handshake     payload
//   input     in         push / full   data_byte[7:0], buffer_end
//   result    out        pop / empty   field_id[3:0], field_value[15:0], last_field
//
// one byte is taken every cycle while full is low; full rises only when two
// decoded frames already wait for the field sequencer
// the sequencer writes one field item per cycle into an eight-entry result queue while it has room,
// so a frame's fields enter the result queue only after its last byte has put the frame into the frame queue
// reset clears parser state and both queue counts; payload bytes hold no reset
// a stalled result side backs up into the frame queue and then into full
module status_frame_deframer_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  input  logic [7:0]  data_byte,
  input  logic        buffer_end,
  output logic        full,
  input  logic        pop,
  output logic        empty,
  output logic [3:0]  field_id,
  output logic [15:0] field_value,
  output logic        last_field
);

  logic job_push;
  logic job_full;
  logic job_valid;
  logic job_pop;
  sfd_pkg::job_t job_in;
  sfd_pkg::job_t job_head;
  logic res_push;
  logic res_full;
  sfd_pkg::res_t res_in;
  sfd_pkg::res_t res_head;

  // byte parser
  sfd_front u_front (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .data_byte (data_byte),
    .buffer_end(buffer_end),
    .job_full  (job_full),
    .full      (full),
    .job_push  (job_push),
    .job_data  (job_in)
  );

  // decoded frame queue
  sfd_job_queue u_job_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (job_push),
    .push_data(job_in),
    .pop      (job_pop),
    .full     (job_full),
    .valid    (job_valid),
    .head     (job_head)
  );

  // field sequencer
  sfd_back u_back (
    .clk      (clk),
    .rst      (rst),
    .job_valid(job_valid),
    .job_data (job_head),
    .res_full (res_full),
    .job_pop  (job_pop),
    .res_push (res_push),
    .res_data (res_in)
  );

  // result queue
  sfd_result_queue u_res_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (res_push),
    .push_data(res_in),
    .pop      (pop),
    .full     (res_full),
    .empty    (empty),
    .head     (res_head)
  );

  // result ports
  assign field_id = res_head.fid;
  assign field_value = res_head.value;
  assign last_field = res_head.last;

endmodule

// ===== bench/testbench.sv =====
// testbench for the status frame deframer: byte stream stimulus with a field predictor
module testbench;

  localparam int BYTE_TARGET = 170;
  localparam int CYCLE_LIMIT = 200000;
  localparam int SETTLE_CYCLES = 16;
  localparam int GAP_MAX = 6;

  typedef enum int {
    FK_STATUS,
    FK_STATUS_SHORT,
    FK_POWER,
    FK_POWER_ODD,
    FK_OTHER,
    FK_CUT,
    FK_NOISE
  } frame_kind_t;

  // predicts decoded fields from the accepted byte stream and checks results
  class deframe_scoreboard_t;
    bit in_frame;
    logic [sfd_pkg::POS_W-1:0] pos;
    logic [15:0] plen;
    logic [15:0] cmd;
    logic [7:0] cap [sfd_pkg::CAPTURE_BYTES];
    sfd_pkg::res_t pending_fields[$];
    int errors;
    int fields_expected;

    function new();
      in_frame = 1'b0;
      pos = '0;
      plen = '0;
      cmd = '0;
      errors = 0;
      fields_expected = 0;
    endfunction

    task report(string msg);
      $display("mismatch at %0t: %s", $realtime, msg);
      errors++;
    endtask

    function void add_field(logic [3:0] id, logic [15:0] value, logic last);
      sfd_pkg::res_t r;
      r.fid = id;
      r.value = value;
      r.last = last;
      pending_fields.push_back(r);
      fields_expected++;
    endfunction

    function logic [15:0] le_word(int lo);
      return {cap[lo+1], cap[lo]};
    endfunction

    function logic [15:0] pm_bit(logic [7:0] mask);
      return ((cap[12] & mask) != 8'h00) ? 16'd1 : 16'd0;
    endfunction

    // fields of a completed frame
    function void decode_frame();
      if (cmd == sfd_pkg::CMD_STATUS && plen >= sfd_pkg::STATUS_MIN_LEN) begin
        add_field(sfd_pkg::FID_ROBOT_ID, {8'h00, cap[0]}, 1'b0);
        add_field(sfd_pkg::FID_LEVEL, {8'h00, cap[1]}, 1'b0);
        add_field(sfd_pkg::FID_HP, le_word(2), 1'b0);
        add_field(sfd_pkg::FID_MAX_HP, le_word(4), 1'b0);
        add_field(sfd_pkg::FID_COOLING, le_word(6), 1'b0);
        add_field(sfd_pkg::FID_HEAT_LIMIT, le_word(8), 1'b0);
        add_field(sfd_pkg::FID_POWER_LIMIT, le_word(10), 1'b0);
        add_field(sfd_pkg::FID_GIMBAL, pm_bit(sfd_pkg::PM_GIMBAL), 1'b0);
        add_field(sfd_pkg::FID_CHASSIS, pm_bit(sfd_pkg::PM_CHASSIS), 1'b0);
        add_field(sfd_pkg::FID_SHOOTER, pm_bit(sfd_pkg::PM_SHOOTER), 1'b1);
      end else if (cmd == sfd_pkg::CMD_POWER && plen == sfd_pkg::POWER_LEN) begin
        add_field(sfd_pkg::FID_BUFFER, le_word(8), 1'b0);
        add_field(sfd_pkg::FID_HEAT17, le_word(10), 1'b0);
        add_field(sfd_pkg::FID_HEAT42, le_word(12), 1'b1);
      end
    endfunction

    // one accepted byte
    function void note_byte(logic [7:0] b, logic bend);
      logic [sfd_pkg::POS_W-1:0] p;
      if (!in_frame) begin
        if (b == sfd_pkg::START_BYTE) begin
          in_frame = 1'b1;
          pos = sfd_pkg::POS_W'(1);
        end
      end else begin
        p = pos;
        if (p == sfd_pkg::POS_LEN_LO) plen[7:0] = b;
        else if (p == sfd_pkg::POS_LEN_HI) plen[15:8] = b;
        else if (p == sfd_pkg::POS_CMD_LO) cmd[7:0] = b;
        else if (p == sfd_pkg::POS_CMD_HI) cmd[15:8] = b;
        else if (p >= sfd_pkg::PAYLOAD_OFFSET &&
                 p - sfd_pkg::PAYLOAD_OFFSET < sfd_pkg::POS_W'(sfd_pkg::CAPTURE_BYTES))
          cap[p - sfd_pkg::PAYLOAD_OFFSET] = b;
        p = p + sfd_pkg::POS_W'(1);
        pos = p;
        if (p >= sfd_pkg::POS_MIN_END && p == sfd_pkg::FRAME_OVERHEAD + {1'b0, plen}) begin
          decode_frame();
          in_frame = 1'b0;
          pos = '0;
        end
      end
      // buffer end drops whatever is unfinished
      if (bend) begin
        in_frame = 1'b0;
        pos = '0;
      end
    endfunction

    // one accepted field item against the oldest prediction
    task check_field(logic [3:0] id, logic [15:0] value, logic last);
      sfd_pkg::res_t want;
      if (pending_fields.size() == 0) begin
        report($sformatf("field id %0d value %h with none expected", id, value));
      end else begin
        want = pending_fields.pop_front();
        if (id !== want.fid)
          report($sformatf("field_id %0d, expected %0d", id, want.fid));
        if (value !== want.value)
          report($sformatf("field %0d value %h, expected %h", want.fid, value, want.value));
        if (last !== want.last)
          report($sformatf("field %0d last_field %b, expected %b", want.fid, last, want.last));
      end
    endtask
  endclass

  logic        clk;
  logic        rst;
  logic        push;
  logic [7:0]  data_byte;
  logic        buffer_end;
  logic        full;
  logic        pop;
  logic        empty;
  logic [3:0]  field_id;
  logic [15:0] field_value;
  logic        last_field;

  deframe_scoreboard_t sb;
  int cycles;
  int bytes_sent;
  bit send_burst;
  bit take_burst;
  logic [7:0] fbytes[$];
  bit fends[$];

  status_frame_deframer_unit i_dut (
    .clk(clk),
    .rst(rst),
    .push(push),
    .data_byte(data_byte),
    .buffer_end(buffer_end),
    .full(full),
    .pop(pop),
    .empty(empty),
    .field_id(field_id),
    .field_value(field_value),
    .last_field(last_field)
  );

  // clock
  always #5 clk = ~clk;

  // cycle limit
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("testbench: done, errors");
      $finish;
    end
  end

  // check every accepted field item
  always @(posedge clk) begin
    if (!rst && pop && !empty)
      sb.check_field(field_id, field_value, last_field);
  end

  // result side: random stalls with stretches of steady popping
  initial begin
    int gap;
    pop = 1'b0;
    take_burst = 1'b0;
    @(negedge rst);
    forever begin
      if ($urandom_range(0, 19) == 0) take_burst = ~take_burst;
      gap = take_burst ? 0 : $urandom_range(0, GAP_MAX);
      if (gap > 0) begin
        pop <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      pop <= 1'b1;
      do @(posedge clk); while (empty);
    end
  end

  // send one byte and wait for it to be taken
  task push_byte(logic [7:0] b, logic bend);
    int gap;
    if ($urandom_range(0, 19) == 0) send_burst = ~send_burst;
    gap = send_burst ? 0 : $urandom_range(0, GAP_MAX);
    if (gap > 0) begin
      push <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    push <= 1'b1;
    data_byte <= b;
    buffer_end <= bend;
    do @(posedge clk); while (full);
    sb.note_byte(b, bend);
    bytes_sent++;
  endtask

  task flush_bytes();
    while (fbytes.size() != 0)
      push_byte(fbytes.pop_front(), fends.pop_front());
  endtask

  // hold the input until every predicted field has been taken
  task wait_all_fields();
    push <= 1'b0;
    @(posedge clk);
    while (sb.pending_fields.size() != 0) @(posedge clk);
  endtask

  function logic [7:0] payload_byte();
    return ($urandom_range(0, 7) == 0) ? sfd_pkg::START_BYTE : 8'($urandom);
  endfunction

  // build one random frame, well-formed, cut short or plain noise
  task send_frame(frame_kind_t kind);
    logic [15:0] len;
    logic [15:0] code;
    int total;
    int cut;
    case (kind)
      FK_STATUS: begin
        code = sfd_pkg::CMD_STATUS;
        len = 16'($urandom_range(13, 20));
      end
      FK_STATUS_SHORT: begin
        code = sfd_pkg::CMD_STATUS;
        len = 16'($urandom_range(0, 12));
      end
      FK_POWER: begin
        code = sfd_pkg::CMD_POWER;
        len = sfd_pkg::POWER_LEN;
      end
      FK_POWER_ODD: begin
        code = sfd_pkg::CMD_POWER;
        len = 16'($urandom_range(0, 24));
        if (len == sfd_pkg::POWER_LEN) len = len + 16'd1;
      end
      FK_OTHER: begin
        code = 16'($urandom);
        len = 16'($urandom_range(0, 10));
      end
      default: begin
        code = ($urandom_range(0, 1) == 0) ? sfd_pkg::CMD_STATUS : 16'($urandom);
        len = 16'($urandom);
      end
    endcase
    if (kind == FK_NOISE) begin
      repeat ($urandom_range(1, 6)) begin
        fbytes.push_back(8'($urandom));
        fends.push_back($urandom_range(0, 7) == 0);
      end
    end else begin
      fbytes.push_back(sfd_pkg::START_BYTE);
      fbytes.push_back(len[7:0]);
      fbytes.push_back(len[15:8]);
      fbytes.push_back(8'($urandom));
      fbytes.push_back(8'($urandom));
      fbytes.push_back(code[7:0]);
      fbytes.push_back(code[15:8]);
      total = int'(sfd_pkg::FRAME_OVERHEAD) + int'(len);
      if (kind == FK_CUT) begin
        cut = $urandom_range(0, (total - 2 < 30) ? total - 2 : 30);
        while (fbytes.size() < cut + 1) fbytes.push_back(payload_byte());
        while (fbytes.size() > cut + 1) void'(fbytes.pop_back());
        repeat (cut) fends.push_back(1'b0);
        fends.push_back(1'b1);
      end else begin
        while (fbytes.size() < total) fbytes.push_back(payload_byte());
        repeat (total - 1) fends.push_back(1'b0);
        // buffer end may also land on the completing byte
        fends.push_back($urandom_range(0, 5) == 0);
      end
    end
    flush_bytes();
    // resync to hunting after noise
    if (kind == FK_NOISE) push_byte(8'($urandom), 1'b1);
  endtask

  // stimulus
  initial begin
    int pick;
    bit paused;
    clk = 1'b0;
    rst = 1'b1;
    push = 1'b0;
    data_byte = 8'h00;
    buffer_end = 1'b0;
    cycles = 0;
    bytes_sent = 0;
    send_burst = 1'b0;
    paused = 1'b0;
    sb = new();
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // shortest status frame with extreme values, a start byte in the payload,
    // all output bits set and buffer end on the completing byte
    fbytes = '{sfd_pkg::START_BYTE, 8'h0D, 8'h00, 8'h00, 8'hFF,
               sfd_pkg::CMD_STATUS[7:0], sfd_pkg::CMD_STATUS[15:8],
               8'h00, 8'hFF, 8'hFF, 8'hFF, 8'h00, 8'h00, sfd_pkg::START_BYTE, 8'h5A,
               8'hFF, 8'h00, 8'h00, 8'hFF, 8'h07, 8'hFF, 8'h00};
    fends = '{0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 1};
    flush_bytes();
    // lone start byte cut by buffer end, then a byte while hunting
    push_byte(sfd_pkg::START_BYTE, 1'b1);
    push_byte(8'h00, 1'b0);
    wait_all_fields();

    // random frames, mostly well formed
    while (bytes_sent < BYTE_TARGET) begin
      pick = $urandom_range(0, 99);
      if (pick < 30) send_frame(FK_STATUS);
      else if (pick < 45) send_frame(FK_POWER);
      else if (pick < 55) send_frame(FK_STATUS_SHORT);
      else if (pick < 65) send_frame(FK_POWER_ODD);
      else if (pick < 75) send_frame(FK_OTHER);
      else if (pick < 88) send_frame(FK_CUT);
      else send_frame(FK_NOISE);
      if (!paused && bytes_sent >= BYTE_TARGET / 2) begin
        paused = 1'b1;
        wait_all_fields();
      end
    end

    wait_all_fields();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (sb.errors == 0) begin
      $display("testbench: done, clean");
    end else begin
      $display("testbench: done, errors");
    end
    $finish;
  end

endmodule
